FILE: hw/rtl/lnrc_pkg.sv
// Package for the LANCE register and ring control block.
// Holds codes, CSR0 bit masks, state, command and status types. No dependencies.
`default_nettype none
package lnrc_pkg;

  localparam int unsigned DMA_REG_COUNT = 4;

  typedef enum logic [2:0] {
    OP_CSR_RD  = 3'd0,
    OP_CSR_WR  = 3'd1,
    OP_DMA_RD  = 3'd2,
    OP_DMA_WR  = 3'd3,
    OP_RX_PKT  = 3'd4,
    OP_TX_POLL = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACCESS    = 2'd0,
    KIND_RX_PLACED = 2'd1,
    KIND_TX_SENT   = 2'd2,
    KIND_RX_DROP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CSR_SEL_0 = 2'd0,
    CSR_SEL_1 = 2'd1,
    CSR_SEL_2 = 2'd2,
    CSR_SEL_3 = 2'd3
  } csr_sel_t;

  localparam logic [15:0] C0_ERR  = 16'h8000;
  localparam logic [15:0] C0_RINT = 16'h0400;
  localparam logic [15:0] C0_TINT = 16'h0200;
  localparam logic [15:0] C0_IDON = 16'h0100;
  localparam logic [15:0] C0_INTR = 16'h0080;
  localparam logic [15:0] C0_INEA = 16'h0040;
  localparam logic [15:0] C0_RXON = 16'h0020;
  localparam logic [15:0] C0_TXON = 16'h0010;
  localparam logic [15:0] C0_STOP = 16'h0004;
  localparam logic [15:0] C0_STRT = 16'h0002;
  localparam logic [15:0] C0_INIT = 16'h0001;
  localparam logic [15:0] C0_W1C  = 16'h7f00;
  localparam logic [15:0] C0_ERRS = 16'h7100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TX,
    ST_TX_END,
    ST_RX
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic tx_step;
    logic tx_end;
    logic rx_step;
    logic rx_place;
    logic rx_drop;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       stopped;
    logic       scan_done;
    logic       slot_rdy;
  } status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lnrc_ctrl.sv
// Controller state machine: sequences access, tx scan and rx scan.
// Depends on lnrc_pkg; drives the datapath lnrc_dp through cmd_t.
`default_nettype none
module lnrc_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  output logic             busy,
  input  lnrc_pkg::status_t st,
  output lnrc_pkg::cmd_t   cmd
);

  lnrc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lnrc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      lnrc_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = lnrc_pkg::ST_EXEC;
        end
      end
      lnrc_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        case (st.op)
          lnrc_pkg::OP_CSR_WR,
          lnrc_pkg::OP_TX_POLL: state_nxt = lnrc_pkg::ST_TX;
          lnrc_pkg::OP_RX_PKT:  state_nxt = lnrc_pkg::ST_RX;
          default:              state_nxt = lnrc_pkg::ST_IDLE;
        endcase
      end
      lnrc_pkg::ST_TX: begin
        if (st.stopped || st.scan_done) begin
          state_nxt = lnrc_pkg::ST_TX_END;
        end else begin
          cmd.tx_step = 1'b1;
        end
      end
      lnrc_pkg::ST_TX_END: begin
        cmd.tx_end = 1'b1;
        state_nxt  = lnrc_pkg::ST_IDLE;
      end
      lnrc_pkg::ST_RX: begin
        if (st.stopped || st.scan_done) begin
          cmd.rx_drop = 1'b1;
          state_nxt   = lnrc_pkg::ST_IDLE;
        end else if (st.slot_rdy) begin
          cmd.rx_place = 1'b1;
          state_nxt    = lnrc_pkg::ST_IDLE;
        end else begin
          cmd.rx_step = 1'b1;
        end
      end
      default: begin
        state_nxt = lnrc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lnrc_dp.sv
// Datapath: CSRs, register pointer, init pointer, DMA words, ring positions,
// slot scan and result registers. Depends on lnrc_pkg; commanded by lnrc_ctrl.
`default_nettype none
module lnrc_dp #(
  parameter int unsigned RING_LOG = 4
) (
  input  wire                clk,
  input  wire                rst_n,
  input  lnrc_pkg::cmd_t     cmd,
  output lnrc_pkg::status_t  st,
  input  wire  [2:0]         in_opcode,
  input  wire                in_port,
  input  wire  [31:0]        in_write_data,
  input  wire  [1:0]         in_dma_index,
  input  wire  [15:0]        in_ready_mask,
  input  wire  [10:0]        in_packet_length,
  output logic               out_valid,
  output logic [1:0]         out_kind,
  output logic [31:0]        out_read_data,
  output logic [3:0]         out_ring_index,
  output logic [10:0]        out_desc_length,
  output logic [31:0]        out_ring_base,
  output logic               out_irq_raise,
  output logic               out_last
);

  logic [2:0]          op_r, op_nxt;
  logic                port_r, port_nxt;
  logic [31:0]         wdata_r, wdata_nxt;
  logic [1:0]          didx_r, didx_nxt;
  logic [15:0]         mask_r, mask_nxt;
  logic [10:0]         plen_r, plen_nxt;

  logic [15:0]         csr_r [4];
  logic [15:0]         csr_nxt [4];
  logic [1:0]          sel_r, sel_nxt;
  logic [31:0]         init_r, init_nxt;
  logic [31:0]         dma_r [lnrc_pkg::DMA_REG_COUNT];
  logic [31:0]         dma_nxt [lnrc_pkg::DMA_REG_COUNT];
  logic [RING_LOG-1:0] rx_pos_r, rx_pos_nxt;
  logic [RING_LOG-1:0] tx_pos_r, tx_pos_nxt;
  logic [RING_LOG-1:0] scan_r, scan_nxt;
  logic [RING_LOG-1:0] stop_r, stop_nxt;
  logic [RING_LOG-1:0] pend_r, pend_nxt;
  logic                pend_vld_r, pend_vld_nxt;

  logic                vld_r, vld_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [31:0]         rdata_r, rdata_nxt;
  logic [3:0]          idx_r, idx_nxt;
  logic [10:0]         dlen_r, dlen_nxt;
  logic                irq_r, irq_nxt;
  logic                last_r, last_nxt;

  logic [RING_LOG+3:0] scan_ext;
  logic [RING_LOG+3:0] pend_ext;
  logic [11:0]         dlen_sum;
  logic [15:0]         v16;

  function automatic logic [15:0] csr0_write(input logic [15:0] cur, input logic [15:0] v);
    logic [15:0] r;
    r = cur;
    if ((v & lnrc_pkg::C0_STOP) != 16'h0) begin
      r = lnrc_pkg::C0_STOP;
    end else begin
      r = r & ~(v & lnrc_pkg::C0_W1C);
      r = r & ~(lnrc_pkg::C0_ERR | lnrc_pkg::C0_INTR);
      if ((r & lnrc_pkg::C0_ERRS) != 16'h0) r = r | lnrc_pkg::C0_ERR;
      if ((r & lnrc_pkg::C0_W1C) != 16'h0) r = r | lnrc_pkg::C0_INTR;
      r = (r & ~lnrc_pkg::C0_INEA) | (v & lnrc_pkg::C0_INEA);
      if ((v & lnrc_pkg::C0_INIT) != 16'h0) begin
        r = (r | lnrc_pkg::C0_IDON | lnrc_pkg::C0_INIT) & ~lnrc_pkg::C0_STOP;
      end else if ((v & lnrc_pkg::C0_STRT) != 16'h0) begin
        r = (r | lnrc_pkg::C0_STRT | lnrc_pkg::C0_RXON | lnrc_pkg::C0_TXON)
            & ~lnrc_pkg::C0_STOP;
      end
    end
    return r;
  endfunction

  assign scan_ext = {4'b0000, scan_r};
  assign pend_ext = {4'b0000, pend_r};
  assign dlen_sum = {1'b0, plen_r} + 12'd4;
  assign v16      = wdata_r[15:0];

  assign st.op        = op_r;
  assign st.stopped   = (csr_r[0] & lnrc_pkg::C0_STOP) != 16'h0;
  assign st.scan_done = (scan_r == stop_r);
  assign st.slot_rdy  = (scan_ext[RING_LOG+3:4] == '0) && mask_r[scan_ext[3:0]];

  always_comb begin
    op_nxt       = op_r;
    port_nxt     = port_r;
    wdata_nxt    = wdata_r;
    didx_nxt     = didx_r;
    mask_nxt     = mask_r;
    plen_nxt     = plen_r;
    csr_nxt      = csr_r;
    sel_nxt      = sel_r;
    init_nxt     = init_r;
    dma_nxt      = dma_r;
    rx_pos_nxt   = rx_pos_r;
    tx_pos_nxt   = tx_pos_r;
    scan_nxt     = scan_r;
    stop_nxt     = stop_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    vld_nxt      = 1'b0;
    kind_nxt     = lnrc_pkg::KIND_ACCESS;
    rdata_nxt    = 32'h0;
    idx_nxt      = 4'h0;
    dlen_nxt     = 11'h0;
    irq_nxt      = 1'b0;
    last_nxt     = 1'b1;

    if (cmd.latch) begin
      op_nxt    = in_opcode;
      port_nxt  = in_port;
      wdata_nxt = in_write_data;
      didx_nxt  = in_dma_index;
      mask_nxt  = in_ready_mask;
      plen_nxt  = in_packet_length;
    end

    if (cmd.exec) begin
      pend_vld_nxt = 1'b0;
      if (op_r == lnrc_pkg::OP_RX_PKT) begin
        scan_nxt = rx_pos_r;
        stop_nxt = rx_pos_r - RING_LOG'(1);
      end else begin
        scan_nxt = tx_pos_r;
        stop_nxt = tx_pos_r - RING_LOG'(1);
      end
      case (op_r)
        lnrc_pkg::OP_CSR_RD: begin
          vld_nxt   = 1'b1;
          rdata_nxt = port_r ? {30'h0, sel_r} : {16'h0, csr_r[sel_r]};
        end
        lnrc_pkg::OP_CSR_WR: begin
          if (port_r) begin
            if (wdata_r[31:2] == 30'h0) sel_nxt = wdata_r[1:0];
          end else begin
            case (sel_r)
              lnrc_pkg::CSR_SEL_0: csr_nxt[0] = csr0_write(csr_r[0], v16);
              lnrc_pkg::CSR_SEL_1: begin
                init_nxt[15:0] = v16;
                csr_nxt[1]     = v16;
              end
              lnrc_pkg::CSR_SEL_2: begin
                init_nxt[31:16] = v16;
                csr_nxt[2]      = v16;
              end
              default: csr_nxt[3] = v16;
            endcase
          end
        end
        lnrc_pkg::OP_DMA_RD: begin
          vld_nxt   = 1'b1;
          rdata_nxt = dma_r[didx_r];
        end
        lnrc_pkg::OP_DMA_WR: begin
          vld_nxt         = 1'b1;
          dma_nxt[didx_r] = wdata_r;
        end
        lnrc_pkg::OP_RX_PKT, lnrc_pkg::OP_TX_POLL: begin
        end
        default: begin
          vld_nxt = 1'b1;
        end
      endcase
    end

    if (cmd.tx_step) begin
      scan_nxt = scan_r + RING_LOG'(1);
      if (st.slot_rdy) begin
        if (pend_vld_r) begin
          vld_nxt  = 1'b1;
          kind_nxt = lnrc_pkg::KIND_TX_SENT;
          idx_nxt  = pend_ext[3:0];
          last_nxt = 1'b0;
        end
        pend_nxt     = scan_r;
        pend_vld_nxt = 1'b1;
        tx_pos_nxt   = tx_pos_r + RING_LOG'(1);
        csr_nxt[0]   = csr_r[0] | lnrc_pkg::C0_TINT | lnrc_pkg::C0_INTR;
      end
    end

    if (cmd.tx_end) begin
      vld_nxt = 1'b1;
      irq_nxt = !st.stopped && ((csr_r[0] & lnrc_pkg::C0_INTR) != 16'h0)
                && ((csr_r[0] & lnrc_pkg::C0_INEA) != 16'h0);
      if (pend_vld_r) begin
        kind_nxt = lnrc_pkg::KIND_TX_SENT;
        idx_nxt  = pend_ext[3:0];
      end
    end

    if (cmd.rx_step) begin
      scan_nxt = scan_r + RING_LOG'(1);
    end

    if (cmd.rx_place) begin
      vld_nxt    = 1'b1;
      kind_nxt   = lnrc_pkg::KIND_RX_PLACED;
      idx_nxt    = scan_ext[3:0];
      dlen_nxt   = dlen_sum[11] ? 11'h7ff : dlen_sum[10:0];
      irq_nxt    = (csr_r[0] & lnrc_pkg::C0_INEA) != 16'h0;
      rx_pos_nxt = rx_pos_r + RING_LOG'(1);
      csr_nxt[0] = csr_r[0] | lnrc_pkg::C0_RINT | lnrc_pkg::C0_INTR;
    end

    if (cmd.rx_drop) begin
      vld_nxt  = 1'b1;
      kind_nxt = lnrc_pkg::KIND_RX_DROP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csr_r[0]   <= lnrc_pkg::C0_STOP;
      csr_r[1]   <= 16'h0;
      csr_r[2]   <= 16'h0;
      csr_r[3]   <= 16'h0;
      sel_r      <= 2'h0;
      init_r     <= 32'h0;
      for (int i = 0; i < lnrc_pkg::DMA_REG_COUNT; i++) dma_r[i] <= 32'h0;
      rx_pos_r   <= '0;
      tx_pos_r   <= '0;
      pend_vld_r <= 1'b0;
      vld_r      <= 1'b0;
    end else begin
      csr_r      <= csr_nxt;
      sel_r      <= sel_nxt;
      init_r     <= init_nxt;
      dma_r      <= dma_nxt;
      rx_pos_r   <= rx_pos_nxt;
      tx_pos_r   <= tx_pos_nxt;
      pend_vld_r <= pend_vld_nxt;
      vld_r      <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    port_r  <= port_nxt;
    wdata_r <= wdata_nxt;
    didx_r  <= didx_nxt;
    mask_r  <= mask_nxt;
    plen_r  <= plen_nxt;
    scan_r  <= scan_nxt;
    stop_r  <= stop_nxt;
    pend_r  <= pend_nxt;
    kind_r  <= kind_nxt;
    rdata_r <= rdata_nxt;
    idx_r   <= idx_nxt;
    dlen_r  <= dlen_nxt;
    irq_r   <= irq_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid       = vld_r;
  assign out_kind        = kind_r;
  assign out_read_data   = rdata_r;
  assign out_ring_index  = idx_r;
  assign out_desc_length = dlen_r;
  assign out_ring_base   = init_r + dma_r[3];
  assign out_irq_raise   = irq_r;
  assign out_last        = last_r;

endmodule
`default_nettype wire

FILE: hw/rtl/lance_nic_register_and_ring_control.sv
// Top level of the LANCE register and ring control block.
// CSR reads, DMA accesses: result word in the cycle after exec; CSR writes also run a tx scan.
// Tx scan: one ring slot per cycle over 2^RING_LOG-1 slots, none while CSR0 STOP is set.
// Rx scan: one slot per cycle until the first ready slot. A new word is taken only when idle.
// Synchronous active-low reset: CSR0 = STOP; other CSRs, pointers, DMA words, ring positions
// and valid flags zero; results cannot be stalled. Depends on lnrc_pkg, lnrc_ctrl and lnrc_dp.
`default_nettype none
module lance_nic_register_and_ring_control #(
  parameter int unsigned RING_LOG = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [2:0]  in_opcode,
  input  wire         in_port,
  input  wire  [31:0] in_write_data,
  input  wire  [1:0]  in_dma_index,
  input  wire  [15:0] in_ready_mask,
  input  wire  [10:0] in_packet_length,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [31:0] out_read_data,
  output logic [3:0]  out_ring_index,
  output logic [10:0] out_desc_length,
  output logic [31:0] out_ring_base,
  output logic        out_irq_raise,
  output logic        out_last
);

  lnrc_pkg::cmd_t    cmd;
  lnrc_pkg::status_t st;

  lnrc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  lnrc_dp #(
    .RING_LOG (RING_LOG)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_opcode        (in_opcode),
    .in_port          (in_port),
    .in_write_data    (in_write_data),
    .in_dma_index     (in_dma_index),
    .in_ready_mask    (in_ready_mask),
    .in_packet_length (in_packet_length),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_read_data    (out_read_data),
    .out_ring_index   (out_ring_index),
    .out_desc_length  (out_desc_length),
    .out_ring_base    (out_ring_base),
    .out_irq_raise    (out_irq_raise),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire

FILE: dv/tb_lance_nic_register_and_ring_control.sv
// Self-checking testbench for the LANCE register and ring control block.
// Drives register, DMA and ring-event words and checks every result word against a
// built-in predictor of CSR, pointer and ring state. Depends on lnrc_pkg and the RTL.
`default_nettype none
module tb_lance_nic_register_and_ring_control;
  timeunit 1ns;
  timeprecision 1ps;

  import lnrc_pkg::*;

  localparam int unsigned RING_LOG    = 4;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 2 ** RING_LOG + 24;
  localparam int unsigned N_RANDOM    = 360;
  localparam int unsigned REPORT_MAX  = 10;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam logic       PORT_RDP   = 1'b0;
  localparam logic       PORT_RAP   = 1'b1;
  localparam logic [10:0] LEN_MAX   = 11'd1544;
  localparam logic [11:0] LEN_SAT   = 12'h7ff;

  typedef struct {
    logic [2:0]  opcode;
    logic        port;
    logic [31:0] wdata;
    logic [1:0]  didx;
    logic [15:0] mask;
    logic [10:0] plen;
    bit          drain;
  } nic_cmd_t;

  typedef struct {
    kind_t       kind;
    logic [31:0] rdata;
    logic [3:0]  idx;
    logic [10:0] dlen;
    logic [31:0] base;
    logic        irq;
    logic        is_last;
  } nic_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_opcode = '0;
  logic        in_port = 1'b0;
  logic [31:0] in_write_data = '0;
  logic [1:0]  in_dma_index = '0;
  logic [15:0] in_ready_mask = '0;
  logic [10:0] in_packet_length = '0;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [31:0] out_read_data;
  logic [3:0]  out_ring_index;
  logic [10:0] out_desc_length;
  logic [31:0] out_ring_base;
  logic        out_irq_raise;
  logic        out_last;

  lance_nic_register_and_ring_control #(
    .RING_LOG(RING_LOG)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_opcode(in_opcode),
    .in_port(in_port),
    .in_write_data(in_write_data),
    .in_dma_index(in_dma_index),
    .in_ready_mask(in_ready_mask),
    .in_packet_length(in_packet_length),
    .out_valid(out_valid),
    .out_kind(out_kind),
    .out_read_data(out_read_data),
    .out_ring_index(out_ring_index),
    .out_desc_length(out_desc_length),
    .out_ring_base(out_ring_base),
    .out_irq_raise(out_irq_raise),
    .out_last(out_last)
  );

  // predicted controller state
  logic [15:0] csr_m [4];
  csr_sel_t    rap_sel;
  logic [31:0] init_ptr;
  logic [31:0] dma_m [4];
  logic [3:0]  rx_pos;
  logic [3:0]  tx_pos;

  nic_cmd_t    cmd_q [$];
  nic_word_t   exp_q [$];
  nic_cmd_t    cur_cmd;
  int unsigned gap_left = 0;
  int unsigned calm_left = 0;
  int unsigned fails = 0;
  int unsigned cycles = 0;
  csr_sel_t    gen_sel;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic nic_word_t make_word(kind_t k, logic [31:0] rdata, logic [3:0] idx,
                                          logic [10:0] dlen, logic irq, logic is_last);
    nic_word_t w;
    w.kind    = k;
    w.rdata   = rdata;
    w.idx     = idx;
    w.dlen    = dlen;
    w.base    = init_ptr + dma_m[3];
    w.irq     = irq;
    w.is_last = is_last;
    return w;
  endfunction

  function automatic logic [15:0] csr0_after_write(logic [15:0] old, logic [15:0] v);
    logic [15:0] r;
    if ((v & C0_STOP) != 16'h0) return C0_STOP;
    r = old & ~(v & C0_W1C);
    r = r & ~(C0_ERR | C0_INTR);
    if ((r & C0_ERRS) != 16'h0) r = r | C0_ERR;
    if ((r & C0_W1C) != 16'h0) r = r | C0_INTR;
    r = (r & ~C0_INEA) | (v & C0_INEA);
    if ((v & C0_INIT) != 16'h0) begin
      r = (r | C0_IDON | C0_INIT) & ~C0_STOP;
    end else if ((v & C0_STRT) != 16'h0) begin
      r = (r | C0_STRT | C0_RXON | C0_TXON) & ~C0_STOP;
    end
    return r;
  endfunction

  task automatic reset_nic_state();
    for (int k = 0; k < 4; k++) begin
      csr_m[k] = 16'h0;
      dma_m[k] = 32'h0;
    end
    csr_m[0] = C0_STOP;
    rap_sel  = CSR_SEL_0;
    init_ptr = 32'h0;
    rx_pos   = 4'h0;
    tx_pos   = 4'h0;
  endtask

  // send every ready tx slot in the window; the final word carries last and irq
  task automatic scan_tx(input logic [15:0] mask);
    logic [3:0] i;
    logic [3:0] stop_at;
    logic       irq;
    logic       found;
    nic_word_t  prev;
    irq   = 1'b0;
    found = 1'b0;
    prev  = make_word(KIND_ACCESS, 32'h0, 4'h0, 11'h0, 1'b0, 1'b1);
    if ((csr_m[0] & C0_STOP) == 16'h0) begin
      stop_at = tx_pos - 4'd1;
      for (i = tx_pos; i != stop_at; i = i + 4'd1) begin
        if (mask[i]) begin
          if (found) exp_q.push_back(prev);
          prev     = make_word(KIND_TX_SENT, 32'h0, i, 11'h0, 1'b0, 1'b0);
          found    = 1'b1;
          tx_pos   = tx_pos + 4'd1;
          csr_m[0] = csr_m[0] | C0_TINT | C0_INTR;
        end
      end
      irq = ((csr_m[0] & C0_INTR) != 16'h0) && ((csr_m[0] & C0_INEA) != 16'h0);
    end
    if (found) begin
      prev.irq     = irq;
      prev.is_last = 1'b1;
      exp_q.push_back(prev);
    end else begin
      exp_q.push_back(make_word(KIND_ACCESS, 32'h0, 4'h0, 11'h0, irq, 1'b1));
    end
  endtask

  task automatic predict_nic(input nic_cmd_t c);
    logic [15:0] v16;
    logic [3:0]  i;
    logic [3:0]  stop_at;
    logic [11:0] dl;
    logic        placed;
    v16 = c.wdata[15:0];
    case (c.opcode)
      OP_CSR_RD: begin
        exp_q.push_back(make_word(KIND_ACCESS,
                                  c.port ? {30'h0, rap_sel} : {16'h0, csr_m[rap_sel]},
                                  4'h0, 11'h0, 1'b0, 1'b1));
      end
      OP_CSR_WR: begin
        if (c.port) begin
          if (c.wdata < 32'd4) rap_sel = csr_sel_t'(c.wdata[1:0]);
        end else begin
          case (rap_sel)
            CSR_SEL_0: csr_m[0] = csr0_after_write(csr_m[0], v16);
            CSR_SEL_1: begin
              init_ptr[15:0] = v16;
              csr_m[1]       = v16;
            end
            CSR_SEL_2: begin
              init_ptr[31:16] = v16;
              csr_m[2]        = v16;
            end
            default: csr_m[3] = v16;
          endcase
        end
        scan_tx(c.mask);
      end
      OP_DMA_RD: begin
        exp_q.push_back(make_word(KIND_ACCESS, dma_m[c.didx], 4'h0, 11'h0, 1'b0, 1'b1));
      end
      OP_DMA_WR: begin
        dma_m[c.didx] = c.wdata;
        exp_q.push_back(make_word(KIND_ACCESS, 32'h0, 4'h0, 11'h0, 1'b0, 1'b1));
      end
      OP_RX_PKT: begin
        placed = 1'b0;
        if ((csr_m[0] & C0_STOP) == 16'h0) begin
          stop_at = rx_pos - 4'd1;
          for (i = rx_pos; i != stop_at && !placed; i = i + 4'd1) begin
            if (c.mask[i]) begin
              placed = 1'b1;
              dl = {1'b0, c.plen} + 12'd4;
              if (dl > LEN_SAT) dl = LEN_SAT;
              rx_pos   = rx_pos + 4'd1;
              csr_m[0] = csr_m[0] | C0_RINT | C0_INTR;
              exp_q.push_back(make_word(KIND_RX_PLACED, 32'h0, i, dl[10:0],
                                        (csr_m[0] & C0_INEA) != 16'h0, 1'b1));
            end
          end
        end
        if (!placed) begin
          exp_q.push_back(make_word(KIND_RX_DROP, 32'h0, 4'h0, 11'h0, 1'b0, 1'b1));
        end
      end
      OP_TX_POLL: scan_tx(c.mask);
      default: begin
        exp_q.push_back(make_word(KIND_ACCESS, 32'h0, 4'h0, 11'h0, 1'b0, 1'b1));
      end
    endcase
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left != 0) begin
      calm_left = calm_left - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(8, 30);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_fail(input string msg);
    if (fails < REPORT_MAX) $display("%0t ns: %s", $realtime, msg);
    fails = fails + 1;
  endtask

  // driver: hold the word while busy, advance from the queue once accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) predict_nic(cur_cmd);
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (cmd_q.size() != 0 && !(cmd_q[0].drain && exp_q.size() != 0)) begin
          cur_cmd = cmd_q.pop_front();
          in_opcode        <= cur_cmd.opcode;
          in_port          <= cur_cmd.port;
          in_write_data    <= cur_cmd.wdata;
          in_dma_index     <= cur_cmd.didx;
          in_ready_mask    <= cur_cmd.mask;
          in_packet_length <= cur_cmd.plen;
          start            <= 1'b1;
          gap_left         <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed word is checked against the oldest expectation
  always @(posedge clk) begin
    nic_word_t e;
    if (rst_n && out_valid) begin
      if (exp_q.size() == 0) begin
        note_fail($sformatf("unexpected word kind %0d ring %0d", out_kind, out_ring_index));
      end else begin
        e = exp_q.pop_front();
        if (out_kind !== e.kind || out_read_data !== e.rdata ||
            out_ring_index !== e.idx || out_desc_length !== e.dlen ||
            out_ring_base !== e.base || out_irq_raise !== e.irq ||
            out_last !== e.is_last) begin
          note_fail($sformatf({"mismatch exp/act: kind %0d/%0d rdata %h/%h ring %0d/%0d ",
                               "len %0d/%0d base %h/%h irq %b/%b last %b/%b"},
                              e.kind, out_kind, e.rdata, out_read_data, e.idx,
                              out_ring_index, e.dlen, out_desc_length, e.base,
                              out_ring_base, e.irq, out_irq_raise, e.is_last, out_last));
        end
      end
    end
  end

  task automatic queue_cmd(input logic [2:0] op, input logic port, input logic [31:0] wdata,
                           input logic [1:0] didx, input logic [15:0] mask,
                           input logic [10:0] plen, input bit drain);
    nic_cmd_t c;
    c.opcode = op;
    c.port   = port;
    c.wdata  = wdata;
    c.didx   = didx;
    c.mask   = mask;
    c.plen   = plen;
    c.drain  = drain;
    cmd_q.push_back(c);
    if (op == OP_CSR_WR && port == PORT_RAP && wdata < 32'd4) gen_sel = csr_sel_t'(wdata[1:0]);
  endtask

  function automatic logic [15:0] rand_mask();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom & $urandom & $urandom);
      2: return 16'($urandom | $urandom);
      default: return 16'h1 << $urandom_range(0, 15);
    endcase
  endfunction

  function automatic logic [10:0] rand_len();
    case ($urandom_range(0, 9))
      0: return 11'h0;
      1: return LEN_MAX;
      default: return 11'($urandom_range(0, LEN_MAX));
    endcase
  endfunction

  function automatic logic [31:0] rand_csr0_go();
    logic [31:0] v;
    v = $urandom;
    v[2] = 1'b0;
    if ($urandom_range(0, 1) != 0) v[0] = 1'b1;
    else v[1] = 1'b1;
    if ($urandom_range(0, 3) != 0) v[6] = 1'b1;
    return v;
  endfunction

  task automatic fill_directed();
    queue_cmd(OP_CSR_RD,  PORT_RDP, 32'h0, 2'd0, 16'h0, 11'h0, 1'b0);
    queue_cmd(OP_CSR_RD,  PORT_RAP, 32'h0, 2'd0, 16'h0, 11'h0, 1'b0);
    queue_cmd(OP_RX_PKT,  PORT_RDP, 32'h0, 2'd0, 16'hffff, 11'd64, 1'b0);
    queue_cmd(OP_TX_POLL, PORT_RDP, 32'h0, 2'd0, 16'hffff, 11'h0, 1'b0);
    queue_cmd(OP_DMA_WR,  PORT_RDP, 32'hffffffff, 2'd3, 16'h0, 11'h0, 1'b0);
    queue_cmd(OP_DMA_WR,  PORT_RAP, 32'h5a5a5a5a, 2'd0, 16'h0, 11'h0, 1'b0);
    queue_cmd(OP_DMA_WR,  PORT_RDP, 32'h80000001, 2'd1, 16'h0, 11'h0, 1'b0);
    queue_cmd(OP_DMA_WR,  PORT_RDP, 32'h0000ffff, 2'd2, 16'h0, 11'h0, 1'b0);
    queue_cmd(OP_DMA_RD,  PORT_RDP, 32'h0, 2'd3, 16'h0, 11'h0, 1'b0);
    queue_cmd(OP_CSR_WR,  PORT_RAP, 32'd1, 2'd0, 16'h0, 11'h0, 1'b0);
    queue_cmd(OP_CSR_WR,  PORT_RDP, 32'hffffffff, 2'd0, 16'h0, 11'h0, 1'b0);
    queue_cmd(OP_CSR_WR,  PORT_RAP, 32'd2, 2'd0, 16'h0, 11'h0, 1'b0);
    queue_cmd(OP_CSR_WR,  PORT_RDP, 32'h0000ffff, 2'd0, 16'h0, 11'h0, 1'b0);
    queue_cmd(OP_CSR_WR,  PORT_RAP, 32'd3, 2'd0, 16'h0, 11'h0, 1'b0);
    queue_cmd(OP_CSR_WR,  PORT_RDP, 32'h0000a5a5, 2'd0, 16'h0, 11'h0, 1'b0);
    queue_cmd(OP_CSR_WR,  PORT_RAP, 32'h00010000, 2'd0, 16'h0, 11'h0, 1'b0);
    queue_cmd(OP_CSR_RD,  PORT_RDP, 32'h0, 2'd0, 16'h0, 11'h0, 1'b0);
    queue_cmd(OP_CSR_WR,  PORT_RAP, 32'd0, 2'd0, 16'h0, 11'h0, 1'b0);
    // init with interrupts enabled and a full ring: longest tx scan
    queue_cmd(OP_CSR_WR,  PORT_RDP, 32'h00000041, 2'd0, 16'hffff, 11'h0, 1'b0);
    queue_cmd(OP_RX_PKT,  PORT_RDP, 32'h0, 2'd0, 16'hffff, 11'h7ff, 1'b1);
    queue_cmd(OP_RX_PKT,  PORT_RDP, 32'h0, 2'd0, 16'h0000, 11'd100, 1'b0);
    queue_cmd(OP_RX_PKT,  PORT_RDP, 32'h0, 2'd0, 16'h8000, 11'h0, 1'b0);
    queue_cmd(OP_CSR_WR,  PORT_RDP, 32'h00007f00, 2'd0, 16'h0, 11'h0, 1'b0);
    queue_cmd(OP_CSR_WR,  PORT_RDP, 32'h00000042, 2'd0, 16'h0001, 11'h0, 1'b0);
    queue_cmd(OP_TX_POLL, PORT_RDP, 32'h0, 2'd0, 16'h0000, 11'h0, 1'b0);
    queue_cmd(OP_SPARE_6, PORT_RAP, 32'hffffffff, 2'd3, 16'hffff, 11'h7ff, 1'b0);
    queue_cmd(OP_SPARE_7, PORT_RDP, 32'h0, 2'd0, 16'h0, 11'h0, 1'b0);
    queue_cmd(OP_CSR_WR,  PORT_RDP, 32'h0000ffff, 2'd0, 16'hffff, 11'h0, 1'b0);
  endtask

  task automatic fill_random(input int unsigned n_items);
    int unsigned target;
    int unsigned r;
    bit          drain;
    logic [31:0] v;
    target = cmd_q.size() + n_items;
    while (cmd_q.size() < target) begin
      r     = $urandom_range(0, 99);
      drain = ($urandom_range(0, 49) == 0);
      if (r < 12) begin
        queue_cmd(OP_CSR_WR, PORT_RAP, 32'd0, 2'($urandom), rand_mask(), rand_len(), drain);
        queue_cmd(OP_CSR_WR, PORT_RDP, rand_csr0_go(), 2'($urandom), rand_mask(),
                  rand_len(), 1'b0);
      end else if (r < 40) begin
        queue_cmd(OP_RX_PKT, 1'($urandom), $urandom, 2'($urandom), rand_mask(),
                  rand_len(), drain);
      end else if (r < 58) begin
        queue_cmd(OP_TX_POLL, 1'($urandom), $urandom, 2'($urandom), rand_mask(),
                  rand_len(), drain);
      end else if (r < 68) begin
        queue_cmd(OP_CSR_RD, 1'($urandom), $urandom, 2'($urandom), rand_mask(),
                  rand_len(), drain);
      end else if (r < 78) begin
        queue_cmd(OP_CSR_WR, PORT_RAP, 32'($urandom_range(0, 3)), 2'($urandom),
                  rand_mask(), rand_len(), drain);
        v = $urandom;
        if (gen_sel == CSR_SEL_0 && $urandom_range(0, 9) != 0) v[2] = 1'b0;
        queue_cmd(OP_CSR_WR, PORT_RDP, v, 2'($urandom), rand_mask(), rand_len(), 1'b0);
      end else if (r < 86) begin
        queue_cmd($urandom_range(0, 1) != 0 ? OP_DMA_WR : OP_DMA_RD, 1'($urandom),
                  $urandom, 2'($urandom), rand_mask(), rand_len(), drain);
      end else if (r < 91) begin
        queue_cmd(OP_CSR_WR, PORT_RAP, $urandom | 32'h4, 2'($urandom), rand_mask(),
                  rand_len(), drain);
      end else if (r < 95) begin
        queue_cmd(OP_CSR_WR, PORT_RAP, 32'd0, 2'($urandom), rand_mask(), rand_len(), drain);
        queue_cmd(OP_CSR_WR, PORT_RDP, $urandom | 32'h4, 2'($urandom), rand_mask(),
                  rand_len(), 1'b0);
      end else begin
        v = $urandom;
        if (gen_sel == CSR_SEL_0) v[2] = 1'b0;
        queue_cmd(OP_CSR_WR, PORT_RDP, v, 2'($urandom), rand_mask(), rand_len(), drain);
      end
    end
  endtask

  initial begin
    reset_nic_state();
    gen_sel = CSR_SEL_0;
    fill_directed();
    fill_random(N_RANDOM);
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (cmd_q.size() != 0 || start || exp_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    while (exp_q.size() != 0) begin
      void'(exp_q.pop_front());
      note_fail("expected word never arrived");
    end
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
